// File: rtl/core/generational_slot_allocator_macros.svh
// Assertion macros used by the slot allocator checker.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define GSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define GSA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/gsa_pkg.sv
// Shared types and constants of the generational slot allocator.
`default_nettype none

package gsa_pkg;

	localparam int HANDLE_W = 32;
	localparam int IDX_W    = 16;
	localparam int GEN_W    = 16;
	localparam int STATUS_W = 2;
	localparam int ROW_W    = 32;  // active bits per bitmap row
	localparam int ROW_SH   = 5;   // log2(ROW_W)

	localparam logic REQ_CREATE  = 1'b0;
	localparam logic REQ_DESTROY = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_CREATED   = 2'd0,
		ST_DESTROYED = 2'd1,
		ST_STALE     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // transaction accepted, issue memory reads
		logic exec;     // read data ready, output free: update stores
		logic scan_rd;  // read bitmap row for free-slot search
		logic scan_ev;  // evaluate bitmap row
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_free;   // output register can take a result
		logic need_scan;  // create reused a slot, search next free one
		logic scan_more;  // search continues in next row
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/gsa_ctrl.sv
// Sequencing state machine of the slot allocator.
`default_nettype none

module gsa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire gsa_pkg::dp_stat_t stat,
	output gsa_pkg::dp_cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_EXEC    = 4'b0010,
		S_SCAN_RD = 4'b0100,
		S_SCAN_EV = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (stat.out_free) begin
					cmd.exec = 1'b1;
					state_d  = stat.need_scan ? S_SCAN_RD : S_IDLE;
				end
			end
			S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = S_SCAN_EV;
			end
			S_SCAN_EV: begin
				cmd.scan_ev = 1'b1;
				state_d     = stat.scan_more ? S_SCAN_RD : S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/gsa_dpath.sv
// Datapath of the slot allocator: generation store, active bitmap, mark and output register.
`default_nettype none

module gsa_dpath #(
	parameter int SLOTS = 1024
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire gsa_pkg::dp_cmd_t                 cmd,
	output gsa_pkg::dp_stat_t                     stat,
	input  wire logic                             req_type,
	input  wire logic [gsa_pkg::HANDLE_W-1:0]     handle,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [gsa_pkg::HANDLE_W-1:0]          new_handle,
	output logic [gsa_pkg::STATUS_W-1:0]          status
);

	localparam int IW    = $clog2(SLOTS);
	localparam int HW    = $clog2(SLOTS + 1);
	localparam int NROWS = (SLOTS + gsa_pkg::ROW_W - 1) / gsa_pkg::ROW_W;
	localparam int RW    = (NROWS > 1) ? $clog2(NROWS) : 1;
	localparam int XW    = RW + gsa_pkg::ROW_SH;
	localparam int SH    = gsa_pkg::ROW_SH;
	localparam int GW    = gsa_pkg::GEN_W;
	localparam int DW    = gsa_pkg::IDX_W;

	function automatic logic [GW-1:0] gen_next(input logic [GW-1:0] g);
		logic [GW-1:0] n;
		n = g + GW'(1);
		if (n == '0) begin
			n = GW'(1);
		end
		return n;
	endfunction

	// stores
	logic [GW-1:0]            gen_mem [SLOTS];
	logic [gsa_pkg::ROW_W-1:0] act_mem [NROWS];

	// control state
	logic [HW-1:0] hw_q, hw_d;
	logic [HW-1:0] minfree_q, minfree_d;
	logic          out_valid_q;

	// payload
	logic                          req_q;
	logic [gsa_pkg::HANDLE_W-1:0]  handle_q;
	logic [GW-1:0]                 gen_rd_q;
	logic [gsa_pkg::ROW_W-1:0]     act_rd_q;
	logic [RW-1:0]                 scan_row_q, scan_row_d;
	logic [gsa_pkg::HANDLE_W-1:0]  new_handle_q;
	logic [gsa_pkg::STATUS_W-1:0]  status_q;

	logic [XW:0]   mf_ext;
	logic [XW:0]   hw_ext;
	logic [IW-1:0] gen_ra;
	logic [RW-1:0] act_ra;

	// exec
	logic                       is_create;
	logic                       at_mark;
	logic                       full;
	logic [GW-1:0]              newgen_c;
	logic [DW-1:0]              idx;
	logic [DW:0]                idx_ext;
	logic                       in_range;
	logic                       del_ok;
	logic                       wr_en;
	logic [IW-1:0]              gen_wa;
	logic [GW-1:0]              gen_wd;
	logic [RW-1:0]              act_wa;
	logic [SH-1:0]              bit_sel;
	logic [gsa_pkg::ROW_W-1:0]  bit_oh;
	logic [gsa_pkg::ROW_W-1:0]  act_wd;

	// scan
	logic [RW:0]                row_ext;
	logic [RW:0]                hw_row;
	logic [RW:0]                nxt_row;
	logic [gsa_pkg::ROW_W-1:0]  row_mask;
	logic [gsa_pkg::ROW_W-1:0]  free_bits;
	logic                       found;
	logic [SH-1:0]              pos;
	logic                       past_mark;

	assign mf_ext = (XW+1)'(minfree_q);
	assign hw_ext = (XW+1)'(hw_q);

	// read addresses
	assign gen_ra = (req_type == gsa_pkg::REQ_CREATE) ? mf_ext[IW-1:0] : handle[IW-1:0];
	always_comb begin
		if (cmd.scan_rd) begin
			act_ra = scan_row_q;
		end else if (req_type == gsa_pkg::REQ_CREATE) begin
			act_ra = mf_ext[XW-1:SH];
		end else begin
			act_ra = handle[XW-1:SH];
		end
	end

	// exec decode
	always_comb begin
		is_create = (req_q == gsa_pkg::REQ_CREATE);
		at_mark   = (minfree_q == hw_q);
		full      = at_mark && (hw_q == HW'(SLOTS));
		newgen_c  = (at_mark || gen_rd_q == '0) ? GW'(1) : gen_rd_q;
		idx       = handle_q[DW-1:0];
		idx_ext   = {1'b0, idx};
		in_range  = idx_ext < (DW+1)'(hw_q);
		del_ok    = in_range && (gen_rd_q == handle_q[gsa_pkg::HANDLE_W-1:DW]);
		wr_en     = cmd.exec && (is_create ? !full : del_ok);
		gen_wa    = is_create ? mf_ext[IW-1:0] : handle_q[IW-1:0];
		gen_wd    = is_create ? newgen_c : gen_next(gen_rd_q);
		act_wa    = is_create ? mf_ext[XW-1:SH] : handle_q[XW-1:SH];
		bit_sel   = is_create ? mf_ext[SH-1:0] : handle_q[SH-1:0];
		bit_oh    = gsa_pkg::ROW_W'(1) << bit_sel;
		act_wd    = is_create ? (act_rd_q | bit_oh) : (act_rd_q & ~bit_oh);
	end

	// free-slot search over one bitmap row
	always_comb begin
		row_ext = {1'b0, scan_row_q};
		hw_row  = hw_ext[XW:SH];
		if (row_ext < hw_row) begin
			row_mask = '1;
		end else if (row_ext == hw_row) begin
			row_mask = (gsa_pkg::ROW_W'(1) << hw_ext[SH-1:0]) - gsa_pkg::ROW_W'(1);
		end else begin
			row_mask = '0;
		end
		free_bits = ~act_rd_q & row_mask;
		found     = |free_bits;
		pos       = '0;
		for (int i = gsa_pkg::ROW_W - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				pos = SH'(i);
			end
		end
		nxt_row   = row_ext + (RW+1)'(1);
		past_mark = {nxt_row, {SH{1'b0}}} >= hw_ext;
	end

	assign stat.out_free  = !out_valid_q || out_ready;
	assign stat.need_scan = is_create && !at_mark;
	assign stat.scan_more = !found && !past_mark;

	// next state of mark and lowest free slot
	always_comb begin
		hw_d       = hw_q;
		minfree_d  = minfree_q;
		scan_row_d = scan_row_q;
		if (cmd.exec) begin
			if (is_create) begin
				if (at_mark && !full) begin
					hw_d      = hw_q + HW'(1);
					minfree_d = minfree_q + HW'(1);
				end
				scan_row_d = mf_ext[XW-1:SH];
			end else if (del_ok && (idx_ext < (DW+1)'(minfree_q))) begin
				minfree_d = idx_ext[HW-1:0];
			end
		end else if (cmd.scan_ev) begin
			if (found) begin
				minfree_d = HW'({scan_row_q, pos});
			end else if (past_mark) begin
				minfree_d = hw_q;
			end else begin
				scan_row_d = nxt_row[RW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			gen_rd_q <= gen_mem[gen_ra];
		end
		if (wr_en) begin
			gen_mem[gen_wa] <= gen_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.scan_rd) begin
			act_rd_q <= act_mem[act_ra];
		end
		if (wr_en) begin
			act_mem[act_wa] <= act_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q        <= '0;
			minfree_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			hw_q      <= hw_d;
			minfree_q <= minfree_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_row_q <= scan_row_d;
		if (cmd.load) begin
			req_q    <= req_type;
			handle_q <= handle;
		end
		if (cmd.exec) begin
			if (is_create) begin
				if (full) begin
					new_handle_q <= '0;
					status_q     <= gsa_pkg::ST_FULL;
				end else begin
					new_handle_q <= {newgen_c, DW'(mf_ext)};
					status_q     <= gsa_pkg::ST_CREATED;
				end
			end else begin
				new_handle_q <= '0;
				status_q     <= del_ok ? gsa_pkg::ST_DESTROYED : gsa_pkg::ST_STALE;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign new_handle = new_handle_q;
	assign status     = status_q;

endmodule

`default_nettype wire

// File: rtl/core/generational_slot_allocator.sv
// Top level of the generational slot allocator.
//
// Input channel (in_valid/in_ready): req_type 0 creates a slot, req_type 1
// destroys the slot named by handle (index in bits 15..0, generation in 31..16).
// Output channel (out_valid/out_ready): one transaction per input transaction,
// new_handle (0 unless a slot was created) and status (created, destroyed,
// stale handle ignored, full).
// The memory reads of the input transaction are registered, the update then runs
// and its result is registered in the output register. A create that reuses a
// freed slot then searches the active bitmap for the next free slot, one 32-slot
// row at a time from the reused slot up to the high-water mark, before the next
// transaction is taken. Transactions do not overlap: each takes a memory read,
// then an update, plus a row read and evaluation per bitmap row searched.
// Reset: the high-water mark and the lowest-free pointer clear; slots at or
// above the mark read as never used, so no clearing pass is needed and the
// block takes transactions as soon as reset is released.
// Output stall: a result waits in the output register; the next transaction
// is still taken, and its update holds until the waiting result leaves.
`default_nettype none

module generational_slot_allocator #(
	parameter int SLOTS = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          req_type,
	input  wire logic [gsa_pkg::HANDLE_W-1:0]  handle,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [gsa_pkg::HANDLE_W-1:0]       new_handle,
	output logic [gsa_pkg::STATUS_W-1:0]       status
);

	gsa_pkg::dp_cmd_t  cmd;
	gsa_pkg::dp_stat_t stat;

	gsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gsa_dpath #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (req_type),
		.handle     (handle),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.new_handle (new_handle),
		.status     (status)
	);

endmodule

`default_nettype wire

// File: rtl/core/gsa_checker.sv
// Port-level checker for the slot allocator, bound to the top level.
`default_nettype none
`include "generational_slot_allocator_macros.svh"

module gsa_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_ready,
	input wire logic                          req_type,
	input wire logic [gsa_pkg::HANDLE_W-1:0]  handle,
	input wire logic                          out_valid,
	input wire logic                          out_ready,
	input wire logic [gsa_pkg::HANDLE_W-1:0]  new_handle,
	input wire logic [gsa_pkg::STATUS_W-1:0]  status
);

	`GSA_ASSERT_IMP(a_zero_handle, out_valid && (status != gsa_pkg::ST_CREATED), new_handle == '0, "handle not zero without create")
	`GSA_ASSERT_IMP(a_gen_nonzero, out_valid && (status == gsa_pkg::ST_CREATED), new_handle[gsa_pkg::HANDLE_W-1:gsa_pkg::IDX_W] != '0, "created handle with generation zero")
	`GSA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "transaction taken while busy")
	`GSA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_handle) && $stable(status), "stalled result changed")

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (.*);

`default_nettype wire
